// ===== src/fwl_pkg.sv =====
// ----------------------------------------------------------------------------
// fwl_pkg
// Shared constants, codes and helpers of the flash record store.
// ----------------------------------------------------------------------------
package fwl_pkg;

  localparam int PAGE_BYTES       = 2048;
  localparam int PAGE_COUNT       = 2;
  localparam int MAX_RECORD_WORDS = 32;

  localparam int PAGE_WORDS  = PAGE_BYTES / 4;
  localparam int FLASH_WORDS = PAGE_WORDS * PAGE_COUNT;
  localparam int CAP_WORDS   = (MAX_RECORD_WORDS < 32) ? MAX_RECORD_WORDS : 32;
  localparam int CAP_BYTES   = CAP_WORDS * 4;

  localparam int FA_W   = $clog2(FLASH_WORDS);
  localparam int OFF_W  = $clog2(PAGE_WORDS + 1);
  localparam int PG_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int SA_W   = (MAX_RECORD_WORDS > 1) ? $clog2(MAX_RECORD_WORDS) : 1;
  localparam int WCNT_W = $clog2(CAP_WORDS + 2);
  localparam int SUM_W  = $clog2(CAP_BYTES * 255 + 1);

  localparam int CMD_W  = 3;
  localparam int ADDR_W = 10;
  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int RB_W   = 8;

  localparam logic [DATA_W-1:0] ALL_ONES  = 32'hffff_ffff;
  localparam logic [RB_W-1:0]   RB_RESET  = 8'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_STAGE    = 3'd0,
    CMD_COMMIT   = 3'd1,
    CMD_READ     = 3'd2,
    CMD_RAW_PROG = 3'd3,
    CMD_RAW_READ = 3'd4
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_RECORD    = 3'd0,
    KIND_NOT_FOUND = 3'd1,
    KIND_COMMIT_OK = 3'd2,
    KIND_VERIFY_NG = 3'd3,
    KIND_RAW       = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_CWORDS,
    ST_CHDR_WR,
    ST_ERASE,
    ST_EMIT,
    ST_RD_ADDR,
    ST_RD_EMIT,
    ST_RAW_WR,
    ST_RAW_CAP
  } state_t;

  function automatic logic [FA_W-1:0] flash_addr(input logic [PG_W-1:0] pg,
                                                 input logic [OFF_W-1:0] off);
    return FA_W'(int'(pg) * PAGE_WORDS + int'(off));
  endfunction

  // sum of the bytes of a word that fall inside the remaining record length
  function automatic logic [9:0] byte_sum(input logic [31:0] w, input logic [RB_W-1:0] rem);
    logic [9:0] s;
    s = '0;
    for (int k = 0; k < 4; k++) begin
      if (int'(rem) > k) s = s + 10'(w[8*k +: 8]);
    end
    return s;
  endfunction

  function automatic logic [31:0] byte_mask(input logic [RB_W-1:0] rem);
    logic [31:0] m;
    m = '0;
    for (int k = 0; k < 4; k++) begin
      if (int'(rem) > k) m[8*k +: 8] = 8'hff;
    end
    return m;
  endfunction

  function automatic logic [RB_W-1:0] rem_dec(input logic [RB_W-1:0] rem);
    return (rem > RB_W'(4)) ? rem - RB_W'(4) : '0;
  endfunction

endpackage

// ===== src/fwl_req_if.sv =====
// ----------------------------------------------------------------------------
// fwl_req_if
// Command request channel of the flash record store.
// ----------------------------------------------------------------------------
interface fwl_req_if;
  logic                         valid;
  logic                         ready;
  logic [fwl_pkg::CMD_W-1:0]    cmd;
  logic [fwl_pkg::ADDR_W-1:0]   address;
  logic [fwl_pkg::DATA_W-1:0]   data;

  modport source (output valid, output cmd, output address, output data, input ready);
  modport sink   (input valid, input cmd, input address, input data, output ready);
endinterface

// ===== src/fwl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fwl_rsp_if
// Result channel of the flash record store.
// ----------------------------------------------------------------------------
interface fwl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fwl_pkg::KIND_W-1:0]   kind;
  logic [fwl_pkg::DATA_W-1:0]   data_res;
  logic [fwl_pkg::ADDR_W-1:0]   slot_address;
  logic                         last;

  modport source (output valid, output kind, output data_res, output slot_address,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_res, input slot_address,
                  input last, output ready);
endinterface

// ===== src/fwl_cfg_if.sv =====
// ----------------------------------------------------------------------------
// fwl_cfg_if
// Record length register write channel.
// ----------------------------------------------------------------------------
interface fwl_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [fwl_pkg::RB_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/fwl_ram.sv =====
// ----------------------------------------------------------------------------
// fwl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fwl_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== src/fwl_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwl_ctrl
// Command sequencer: slot scan, commit read-modify-write, erase sweeps,
// record readout, staging buffer and result register.
// ----------------------------------------------------------------------------
module fwl_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  fwl_req_if.sink                  req,
  fwl_rsp_if.source                rsp,
  fwl_cfg_if.sink                  cfg,
  output logic                     ram_we,
  output logic [fwl_pkg::FA_W-1:0] ram_waddr,
  output logic [31:0]              ram_wdata,
  output logic                     ram_re,
  output logic [fwl_pkg::FA_W-1:0] ram_raddr,
  input  logic [31:0]              ram_rdata
);
  import fwl_pkg::*;

  state_t state, state_next;

  logic [RB_W-1:0]   rb;
  logic [RB_W-1:0]   rb_eff;
  logic [WCNT_W-1:0] words;
  logic [WCNT_W-1:0] sw;

  cmd_t              cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [31:0]       data_q;

  logic [31:0] stage [MAX_RECORD_WORDS];
  logic [31:0] sdata;

  // scan issue side
  logic [PG_W-1:0]   pg;
  logic [OFF_W-1:0]  off;
  logic [WCNT_W-1:0] j;
  logic [OFF_W-1:0]  cur_base;
  logic              fits;
  logic              pg_last;
  // scan return side
  logic              t_vld;
  logic [WCNT_W-1:0] t_j;
  logic [PG_W-1:0]   t_pg;
  logic [OFF_W-1:0]  t_off;
  logic [31:0]       hdr;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_new;
  logic [RB_W-1:0]   rem;
  logic              any_f;
  logic [PG_W-1:0]   any_pg;
  logic [OFF_W-1:0]  any_off;
  logic              val_f;
  logic [PG_W-1:0]   val_pg;
  logic [OFF_W-1:0]  val_off;

  // commit
  logic [PG_W-1:0]   wr_pg;
  logic [OFF_W-1:0]  wr_off;
  logic [WCNT_W-1:0] i;
  logic              w_vld;
  logic [FA_W-1:0]   w_addr;
  logic [SUM_W-1:0]  cs_sum;
  logic [SUM_W-1:0]  wsum;
  logic [31:0]       w_word;

  // erase sweep
  logic [PG_W-1:0]   e_pg;
  logic [OFF_W-1:0]  e_off;
  logic              e_end;

  kind_t             res_kind;
  logic [31:0]       res_data;
  logic [ADDR_W-1:0] res_addr;

  logic              out_valid;
  kind_t             out_kind;
  logic [31:0]       out_data;
  logic [ADDR_W-1:0] out_addr;
  logic              out_last;
  logic              out_free;
  logic              raw_in_range;

  always_comb begin
    rb_eff = rb;
    if (rb == '0) rb_eff = RB_W'(1);
    if (int'(rb) > CAP_BYTES) rb_eff = RB_W'(CAP_BYTES);
  end

  assign words        = WCNT_W'(({1'b0, rb_eff} + 9'd3) >> 2);
  assign sw           = words + WCNT_W'(1);
  assign fits         = (int'(off) + int'(sw)) <= PAGE_WORDS;
  assign pg_last      = int'(pg) == PAGE_COUNT - 1;
  assign e_end        = (int'(e_pg) == PAGE_COUNT - 1) && (int'(e_off) == PAGE_WORDS - 1);
  assign out_free     = !out_valid || rsp.ready;
  assign raw_in_range = int'(req.address) < FLASH_WORDS;
  assign sum_new      = sum + SUM_W'(byte_sum(ram_rdata, rem));
  assign w_word       = ram_rdata & sdata;

  assign cfg.ready        = 1'b1;
  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.kind         = out_kind;
  assign rsp.data_res     = out_data;
  assign rsp.slot_address = out_addr;
  assign rsp.last         = out_last;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    if (w_vld) begin
      ram_we    = 1'b1;
      ram_waddr = w_addr;
      ram_wdata = w_word;
    end
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = flash_addr(e_pg, e_off);
        ram_wdata = ALL_ONES;
        if (e_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid) begin
          case (req.cmd)
            CMD_COMMIT, CMD_READ: state_next = ST_SCAN;
            CMD_RAW_PROG: begin
              if (raw_in_range) begin
                ram_re     = 1'b1;
                ram_raddr  = FA_W'(req.address);
                state_next = ST_RAW_WR;
              end
            end
            CMD_RAW_READ: begin
              if (raw_in_range) begin
                ram_re     = 1'b1;
                ram_raddr  = FA_W'(req.address);
                state_next = ST_RAW_CAP;
              end else begin
                state_next = ST_EMIT;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (j == '0 && !fits) begin
          if (pg_last) state_next = ST_DECIDE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = flash_addr(pg, off);
        end
      end
      ST_DECIDE: begin
        if (cmd_q == CMD_COMMIT) state_next = ST_CWORDS;
        else if (val_f)          state_next = ST_RD_ADDR;
        else                     state_next = ST_EMIT;
      end
      ST_CWORDS: begin
        ram_re = 1'b1;
        if (i < words) begin
          ram_raddr = flash_addr(wr_pg, OFF_W'(int'(wr_off) + 1 + int'(i)));
        end else begin
          ram_raddr  = flash_addr(wr_pg, wr_off);
          state_next = ST_CHDR_WR;
        end
      end
      ST_CHDR_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = flash_addr(wr_pg, wr_off);
        ram_wdata  = ram_rdata & 32'(cs_sum);
        state_next = (cs_sum == wsum) ? ST_ERASE : ST_EMIT;
      end
      ST_ERASE: begin
        ram_we    = (e_pg != wr_pg);
        ram_waddr = flash_addr(e_pg, e_off);
        ram_wdata = ALL_ONES;
        if (e_end) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_RD_ADDR: begin
        ram_re     = 1'b1;
        ram_raddr  = flash_addr(val_pg, OFF_W'(int'(val_off) + 1 + int'(i)));
        state_next = ST_RD_EMIT;
      end
      ST_RD_EMIT: begin
        if (out_free) state_next = (i == words - WCNT_W'(1)) ? ST_IDLE : ST_RD_ADDR;
      end
      ST_RAW_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = FA_W'(addr_q);
        ram_wdata  = ram_rdata & data_q;
        state_next = ST_IDLE;
      end
      ST_RAW_CAP: state_next = ST_EMIT;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rb        <= RB_RESET;
      out_valid <= 1'b0;
      t_vld     <= 1'b0;
      w_vld     <= 1'b0;
      e_pg      <= '0;
      e_off     <= '0;
      for (int k = 0; k < MAX_RECORD_WORDS; k++) stage[k] <= '0;
    end else begin
      t_vld <= 1'b0;
      w_vld <= 1'b0;
      if (cfg.valid) rb <= cfg.data;
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;

      // slot scan return path
      if (t_vld) begin
        if (t_j == '0) begin
          hdr <= ram_rdata;
          sum <= '0;
          rem <= rb_eff;
        end else begin
          sum <= sum_new;
          rem <= rem_dec(rem);
          if (t_j == words && hdr != ALL_ONES) begin
            any_f   <= 1'b1;
            any_pg  <= t_pg;
            any_off <= t_off;
            if (hdr == 32'(sum_new)) begin
              val_f   <= 1'b1;
              val_pg  <= t_pg;
              val_off <= t_off;
            end
          end
        end
      end

      // commit word return path
      if (w_vld) begin
        cs_sum <= cs_sum + SUM_W'(byte_sum(sdata, rem));
        wsum   <= wsum + SUM_W'(byte_sum(w_word, rem));
        rem    <= rem_dec(rem);
      end

      case (state)
        ST_CLEAR, ST_ERASE: begin
          if (int'(e_off) == PAGE_WORDS - 1) begin
            e_off <= '0;
            e_pg  <= (int'(e_pg) == PAGE_COUNT - 1) ? '0 : e_pg + PG_W'(1);
          end else begin
            e_off <= e_off + OFF_W'(1);
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            cmd_q  <= cmd_t'(req.cmd);
            addr_q <= req.address;
            data_q <= req.data;
            pg     <= '0;
            off    <= '0;
            j      <= '0;
            any_f  <= 1'b0;
            val_f  <= 1'b0;
            if (req.cmd == CMD_STAGE && int'(req.address) < MAX_RECORD_WORDS) begin
              stage[SA_W'(req.address)] <= req.data;
            end
            res_kind <= KIND_RAW;
            res_data <= ALL_ONES;
            res_addr <= req.address;
          end
        end
        ST_SCAN: begin
          if (j == '0 && !fits) begin
            if (!pg_last) begin
              pg  <= pg + PG_W'(1);
              off <= '0;
            end
          end else begin
            t_vld <= 1'b1;
            t_j   <= j;
            t_pg  <= pg;
            t_off <= (j == '0) ? off : cur_base;
            if (j == '0) cur_base <= off;
            off <= off + OFF_W'(1);
            j   <= (j == words) ? '0 : j + WCNT_W'(1);
          end
        end
        ST_DECIDE: begin
          i        <= '0;
          rem      <= rb_eff;
          cs_sum   <= '0;
          wsum     <= '0;
          res_kind <= KIND_NOT_FOUND;
          res_data <= '0;
          res_addr <= '0;
          // slot after the newest written one, wrapping to the next page
          if (!any_f) begin
            wr_pg  <= '0;
            wr_off <= '0;
          end else if (int'(any_off) + 2 * int'(sw) > PAGE_WORDS) begin
            wr_off <= '0;
            wr_pg  <= (int'(any_pg) == PAGE_COUNT - 1) ? '0 : any_pg + PG_W'(1);
          end else begin
            wr_pg  <= any_pg;
            wr_off <= OFF_W'(int'(any_off) + int'(sw));
          end
        end
        ST_CWORDS: begin
          if (i < words) begin
            sdata  <= stage[SA_W'(i)];
            w_vld  <= 1'b1;
            w_addr <= flash_addr(wr_pg, OFF_W'(int'(wr_off) + 1 + int'(i)));
            i      <= i + WCNT_W'(1);
          end
        end
        ST_CHDR_WR: begin
          res_kind <= (cs_sum == wsum) ? KIND_COMMIT_OK : KIND_VERIFY_NG;
          res_data <= 32'(cs_sum);
          res_addr <= ADDR_W'(flash_addr(wr_pg, wr_off));
          e_pg     <= '0;
          e_off    <= '0;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= res_kind;
            out_data  <= res_data;
            out_addr  <= res_addr;
            out_last  <= 1'b1;
          end
        end
        ST_RD_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_RECORD;
            out_data  <= ram_rdata & byte_mask(rem);
            out_addr  <= ADDR_W'(flash_addr(val_pg, val_off));
            out_last  <= (i == words - WCNT_W'(1));
            i         <= i + WCNT_W'(1);
            rem       <= rem_dec(rem);
          end
        end
        ST_RAW_CAP: begin
          res_kind <= KIND_RAW;
          res_data <= ram_rdata;
          res_addr <= addr_q;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== src/flash_record_wear_leveling_store.sv =====
// ----------------------------------------------------------------------------
// flash_record_wear_leveling_store
// Record store over a modeled flash array with slot wear leveling.
// ----------------------------------------------------------------------------
//  channel | dir | payload                               | request when
//  req     | in  | cmd, address, data                    | valid & ready
//  rsp     | out | kind, data_res, slot_address, last    | valid & ready
//  cfg     | in  | data (record length in bytes)         | valid & ready
//
//  stage, raw program and raw read do not scan the flash; commit and read scan
//  the flash slot by slot through the single read port; a commit then programs
//  the record words and the header and, when the check passes, sweeps all
//  flash words to erase every page but the written one; a read then emits the
//  record words one by one.
//  after reset a clearing pass over all FLASH_WORDS words (1024) erases the
//  array before the first request is taken; cfg is taken at any time.
//  a held result does not block the next request; a stalled rsp stalls the
//  command sequencer only when it has another result to hand over.
// ----------------------------------------------------------------------------
module flash_record_wear_leveling_store (
  input  logic      clk,
  input  logic      rst,
  fwl_req_if.sink   req,
  fwl_rsp_if.source rsp,
  fwl_cfg_if.sink   cfg
);
  import fwl_pkg::*;

  logic            ram_we;
  logic [FA_W-1:0] ram_waddr;
  logic [31:0]     ram_wdata;
  logic            ram_re;
  logic [FA_W-1:0] ram_raddr;
  logic [31:0]     ram_rdata;

  fwl_ram #(
    .DEPTH (FLASH_WORDS),
    .WIDTH (32)
  ) u_flash (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fwl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg       (cfg),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );
endmodule
